### hdl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg: shared constants and types for the nearest palette color search
// Palette geometry, distance widths, command codes and the distance unit tag.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  localparam int PalEntries   = 256;
  localparam int PalIdxW      = (PalEntries > 1) ? $clog2(PalEntries) : 1;
  localparam int CompareShift = 8;
  localparam int CompW        = 16;
  localparam int KeyW         = CompW - CompareShift;
  // three squares of an 8-bit difference need 18 bits
  localparam int DistW        = 2 * KeyW + 2;
  localparam int BestW        = 17;
  localparam logic [BestW-1:0] StartDist = BestW'(100000);

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdMatch = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [KeyW-1:0] r;
    logic [KeyW-1:0] g;
    logic [KeyW-1:0] b;
  } rgb_key_t;

  typedef struct packed {
    logic               vld;
    logic [PalIdxW-1:0] idx;
  } scan_tag_t;

endpackage

`default_nettype wire

### hdl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest palette color by squared RGB distance
// Holds a 256-entry palette; load transfers write it, match transfers scan it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: tuser is the command (0 load, 1 match). tdata carries, from
//   bit 0 up, entry_index[7:0], red_in[15:0], green_in[15:0], blue_in[15:0].
//   A load writes one palette entry and gives no result.
//   A match scans entries 0 .. 255, one per cycle, through the palette RAM
//   read port and a two-stage distance unit, then reads the winning entry
//   back. tvalid rises once the scan reads are done, the read and distance
//   pipeline has drained, the scan is left, the winning entry is read back
//   and the result is loaded. No new transfer is taken until the block is
//   back in idle, so one match must finish before the next is taken.
//   Master side: tdata carries best_index, best_distance, match_red,
//   match_green, match_blue (zero padded to 80 bits); tuser is is_black.
//   The result sits in an output register, so a load or a new match may be
//   taken while it waits; a finished scan holds until that register is free.
//   Reset clears control state only. Palette contents are undefined until
//   loaded; a match must only be issued once every entry has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index[7:0], red_in[23:8], green_in[39:24], blue_in[55:40]
  input  wire logic [55:0] s_axis_tdata,
  // cmd[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // best_index[7:0], best_distance[24:8], match_red[40:25],
  // match_green[56:41], match_blue[72:57], zero pad [79:73]
  output logic [79:0]      m_axis_tdata,
  // is_black[0]
  output logic             m_axis_tuser
);

  localparam int IdxW  = npcs_pkg::PalIdxW;
  localparam int CntW  = IdxW + 1;
  localparam int EntW  = 3 * npcs_pkg::CompW;
  localparam int CompW = npcs_pkg::CompW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [npcs_pkg::BestW-1:0] best_dist_q, best_dist_d;
  npcs_pkg::rgb_key_t want_q;
  npcs_pkg::scan_tag_t rd_tag_q, rd_tag_d, dist_tag;
  logic [npcs_pkg::DistW-1:0] cand_dist;

  logic [EntW-1:0] palette_mem [npcs_pkg::PalEntries];
  logic [EntW-1:0] rd_data_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;

  logic            in_xfer, out_xfer, issue, better, out_load;
  logic [CompW-1:0] in_r, in_g, in_b, ent_r, ent_g, ent_b;
  npcs_pkg::rgb_key_t entry_key;

  logic             out_valid_q;
  logic [7:0]       out_idx_q;
  logic [npcs_pkg::BestW-1:0] out_dist_q;
  logic [CompW-1:0] out_r_q, out_g_q, out_b_q;
  logic             out_black_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign in_r = s_axis_tdata[23:8];
  assign in_g = s_axis_tdata[39:24];
  assign in_b = s_axis_tdata[55:40];

  assign s_axis_tready = (state_q == S_IDLE);

  // palette RAM: one write port, one registered read port
  assign wr_en   = in_xfer && (s_axis_tuser == npcs_pkg::CmdLoad)
                && (32'(s_axis_tdata[7:0]) < 32'(npcs_pkg::PalEntries));
  assign wr_addr = IdxW'(s_axis_tdata[7:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      palette_mem[wr_addr] <= {in_b, in_g, in_r};
    end
    if (rd_en) begin
      rd_data_q <= palette_mem[rd_addr];
    end
  end

  assign ent_r = rd_data_q[CompW-1:0];
  assign ent_g = rd_data_q[2*CompW-1:CompW];
  assign ent_b = rd_data_q[3*CompW-1:2*CompW];
  assign entry_key.r = ent_r[CompW-1:npcs_pkg::CompareShift];
  assign entry_key.g = ent_g[CompW-1:npcs_pkg::CompareShift];
  assign entry_key.b = ent_b[CompW-1:npcs_pkg::CompareShift];

  npcs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .want_i  (want_q),
    .entry_i (entry_key),
    .tag_o   (dist_tag),
    .dist_o  (cand_dist)
  );

  assign issue    = (state_q == S_SCAN) && (cnt_q < CntW'(npcs_pkg::PalEntries));
  assign better   = dist_tag.vld && (cand_dist < npcs_pkg::DistW'(best_dist_q));
  assign out_load = (state_q == S_WAIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[IdxW-1:0];
    rd_tag_d    = '0;
    if (better) begin
      best_idx_d  = dist_tag.idx;
      best_dist_d = npcs_pkg::BestW'(cand_dist);
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (s_axis_tuser == npcs_pkg::CmdMatch)) begin
          cnt_d       = '0;
          best_idx_d  = '0;
          best_dist_d = npcs_pkg::StartDist;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_en        = 1'b1;
          rd_tag_d.vld = 1'b1;
          rd_tag_d.idx = cnt_q[IdxW-1:0];
          cnt_d        = cnt_q + CntW'(1);
        end else if (!rd_tag_q.vld && !dist_tag.vld) begin
          // scan drained: read back the winning entry
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = best_idx_q;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_tag_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_tag_q <= rd_tag_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    if (in_xfer && (s_axis_tuser == npcs_pkg::CmdMatch)) begin
      want_q.r <= in_r[CompW-1:npcs_pkg::CompareShift];
      want_q.g <= in_g[CompW-1:npcs_pkg::CompareShift];
      want_q.b <= in_b[CompW-1:npcs_pkg::CompareShift];
    end
    if (out_load) begin
      out_idx_q   <= 8'(best_idx_q);
      out_dist_q  <= best_dist_q;
      out_r_q     <= ent_r;
      out_g_q     <= ent_g;
      out_b_q     <= ent_b;
      out_black_q <= (rd_data_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_b_q, out_g_q, out_r_q, out_dist_q, out_idx_q};
  assign m_axis_tuser  = out_black_q;

  // no scan work in flight while the block takes new transfers
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !rd_tag_q.vld && !dist_tag.vld)
    else $error("distance pipeline busy while idle");

  // the running best never rises above the start value during a scan
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> best_dist_q <= npcs_pkg::StartDist)
    else $error("best distance out of range");

  // a taken result is not shown again unless a new one is loaded
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_load |=> !m_axis_tvalid)
    else $error("result repeated after transfer");

  // a result is loaded only after the winning entry was read back
  a_fetch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_WAIT) |-> $past(state_q) == S_FETCH)
    else $error("result stage entered without readback");

endmodule

`default_nettype wire

### hdl/npcs_dist.sv
// ----------------------------------------------------------------------------
// npcs_dist: two-stage squared RGB distance unit
// Stage one squares the three component differences, stage two sums them.
// The palette index travels alongside as a tag.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_dist (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire npcs_pkg::scan_tag_t               tag_i,
  input  wire npcs_pkg::rgb_key_t                want_i,
  input  wire npcs_pkg::rgb_key_t                entry_i,
  output npcs_pkg::scan_tag_t                    tag_o,
  output logic [npcs_pkg::DistW-1:0]             dist_o
);

  localparam int SqW = 2 * npcs_pkg::KeyW;

  logic [npcs_pkg::KeyW-1:0] diff_r, diff_g, diff_b;
  logic [SqW-1:0]            sq_r_d, sq_g_d, sq_b_d;
  logic [SqW-1:0]            sq_r_q, sq_g_q, sq_b_q;
  npcs_pkg::scan_tag_t       tag1_q, tag2_q;
  logic [npcs_pkg::DistW-1:0] dist_q;

  always_comb begin
    diff_r = (want_i.r >= entry_i.r) ? want_i.r - entry_i.r : entry_i.r - want_i.r;
    diff_g = (want_i.g >= entry_i.g) ? want_i.g - entry_i.g : entry_i.g - want_i.g;
    diff_b = (want_i.b >= entry_i.b) ? want_i.b - entry_i.b : entry_i.b - want_i.b;
    sq_r_d = SqW'(diff_r) * SqW'(diff_r);
    sq_g_d = SqW'(diff_g) * SqW'(diff_g);
    sq_b_d = SqW'(diff_b) * SqW'(diff_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_r_d;
    sq_g_q <= sq_g_d;
    sq_b_q <= sq_b_d;
    dist_q <= npcs_pkg::DistW'(sq_r_q) + npcs_pkg::DistW'(sq_g_q)
            + npcs_pkg::DistW'(sq_b_q);
  end

  assign tag_o  = tag2_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

### tb/sv/nearest_palette_color_search_tb.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_tb: self-checking bench for the palette search
// Loads the palette, issues match transfers and checks every result against
// an in-bench nearest-color predictor, under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;

  typedef struct packed {
    logic [7:0]                 index;
    logic [npcs_pkg::BestW-1:0] distance;
    logic [15:0]                red;
    logic [15:0]                green;
    logic [15:0]                blue;
    logic                       black;
  } nearest_t;

  localparam int IdleHeavy   = 68;
  localparam int IdleLight   = 9;
  localparam int SettleCycles = 300;
  localparam int MaxReports  = 10;
  localparam int TrafficItems = 380;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  // palette as the predictor sees it
  logic [15:0] pal_red   [npcs_pkg::PalEntries];
  logic [15:0] pal_green [npcs_pkg::PalEntries];
  logic [15:0] pal_blue  [npcs_pkg::PalEntries];

  nearest_t nearest_q[$];
  int       mismatches  = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       hold_left    = 0;

  nearest_palette_color_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Scan every entry from 0 up; a strictly smaller distance replaces the best.
  function automatic nearest_t find_nearest(input logic [15:0] r, g, b);
    nearest_t    res;
    int          dr, dg, db;
    int unsigned d, best_d, best_i;
    best_d = npcs_pkg::StartDist;
    best_i = 0;
    for (int i = 0; i < npcs_pkg::PalEntries; i++) begin
      dr = int'(r[15:npcs_pkg::CompareShift])
         - int'(pal_red[i][15:npcs_pkg::CompareShift]);
      dg = int'(g[15:npcs_pkg::CompareShift])
         - int'(pal_green[i][15:npcs_pkg::CompareShift]);
      db = int'(b[15:npcs_pkg::CompareShift])
         - int'(pal_blue[i][15:npcs_pkg::CompareShift]);
      d = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    res.index    = 8'(best_i);
    res.distance = npcs_pkg::BestW'(best_d);
    res.red      = pal_red[best_i];
    res.green    = pal_green[best_i];
    res.blue     = pal_blue[best_i];
    res.black    = (pal_red[best_i] == 16'h0) && (pal_green[best_i] == 16'h0) &&
                   (pal_blue[best_i] == 16'h0);
    return res;
  endfunction

  // Offer one item and hold it until the transfer; valid stays high on return.
  task automatic send_item(input npcs_pkg::cmd_e cmd, input logic [7:0] idx,
                           input logic [15:0] r, g, b);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {b, g, r, idx};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    if (cmd == npcs_pkg::CmdMatch) begin
      nearest_q.push_back(find_nearest(r, g, b));
    end else begin
      pal_red[idx]   = r;
      pal_green[idx] = g;
      pal_blue[idx]  = b;
    end
  endtask

  task automatic wait_results_drained(input int settle);
    s_axis_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic check_result();
    nearest_t want;
    nearest_t got;
    got.index    = m_axis_tdata[7:0];
    got.distance = m_axis_tdata[24:8];
    got.red      = m_axis_tdata[40:25];
    got.green    = m_axis_tdata[56:41];
    got.blue     = m_axis_tdata[72:57];
    got.black    = m_axis_tuser;
    if (nearest_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: result with no match pending: idx=%0d dist=%0d", $realtime,
                 got.index, got.distance);
    end else begin
      want = nearest_q.pop_front();
      if (got.index !== want.index || got.distance !== want.distance ||
          got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.black !== want.black) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: expected idx=%0d dist=%0d rgb=%h/%h/%h black=%b,", $realtime,
                   want.index, want.distance, want.red, want.green, want.blue,
                   want.black, " got idx=%0d dist=%0d rgb=%h/%h/%h black=%b",
                   got.index, got.distance, got.red, got.green, got.blue,
                   got.black);
      end
    end
  endtask

  // Result side: check each transfer, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      check_result();
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Every entry must be written before the first match.
  task automatic test_fill_palette();
    for (int i = 0; i < npcs_pkg::PalEntries; i++)
      send_item(npcs_pkg::CmdLoad, 8'(i), 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_no_closer_entry();
    // all white: black is farther than the start distance everywhere
    send_item(npcs_pkg::CmdMatch, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    // mid gray ties on every entry, lowest index wins
    send_item(npcs_pkg::CmdMatch, 8'hFF, 16'h8000, 16'h8000, 16'h8000);
  endtask

  task automatic test_ties_and_black();
    send_item(npcs_pkg::CmdLoad, 8'd255, 16'h0000, 16'h0000, 16'h0000);
    send_item(npcs_pkg::CmdMatch, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_item(npcs_pkg::CmdLoad, 8'd128, 16'h0000, 16'h0000, 16'h0000);
    send_item(npcs_pkg::CmdMatch, 8'h00, 16'h00FF, 16'h0000, 16'h0000);
    // zero upper bytes but not black: distance zero, flag clear
    send_item(npcs_pkg::CmdLoad, 8'd0, 16'h00FF, 16'h00FF, 16'h00FF);
    send_item(npcs_pkg::CmdMatch, 8'h55, 16'h00FF, 16'h00FF, 16'h00FF);
  endtask

  task automatic test_component_extremes();
    send_item(npcs_pkg::CmdLoad, 8'd77, 16'h12AB, 16'h34CD, 16'h56EF);
    send_item(npcs_pkg::CmdMatch, 8'hAA, 16'h12AB, 16'h34CD, 16'h56EF);
    send_item(npcs_pkg::CmdMatch, 8'h00, 16'h1300, 16'h3355, 16'h5600);
    send_item(npcs_pkg::CmdMatch, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int n);
    logic [7:0]  idx;
    logic [15:0] r, g, b;
    int          pick;
    for (int k = 0; k < n; k++) begin
      idx  = 8'($urandom);
      pick = $urandom_range(npcs_pkg::PalEntries - 1);
      if ($urandom_range(99) < 50) begin
        case ($urandom_range(15))
          0: {r, g, b} = 48'h0;
          1: {r, g, b} = {48{1'b1}};
          2: {r, g, b} = {pal_red[pick], pal_green[pick], pal_blue[pick]};
          default: {r, g, b} = {16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        send_item(npcs_pkg::CmdLoad, idx, r, g, b);
      end else begin
        if ($urandom_range(99) < 60) begin
          // near a known entry: flip low key bits, random low byte
          r = {pal_red[pick][15:8] ^ 8'($urandom_range(3)), 8'($urandom)};
          g = {pal_green[pick][15:8] ^ 8'($urandom_range(3)), 8'($urandom)};
          b = {pal_blue[pick][15:8] ^ 8'($urandom_range(3)), 8'($urandom)};
        end else begin
          {r, g, b} = {16'($urandom), 16'($urandom), 16'($urandom)};
        end
        send_item(npcs_pkg::CmdMatch, idx, r, g, b);
      end
    end
  endtask

  task automatic test_random_palette();
    for (int i = 0; i < npcs_pkg::PalEntries; i++)
      send_item(npcs_pkg::CmdLoad, 8'(i), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Hold the result side off long enough that the block stalls its input.
  task automatic test_output_backpressure();
    hold_left = 3000;
    for (int k = 0; k < 6; k++) begin
      send_item(npcs_pkg::CmdMatch, 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
      send_item(npcs_pkg::CmdLoad, 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
    wait_results_drained(0);
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 4; k++)
      send_item(npcs_pkg::CmdMatch, 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    wait_results_drained(0);
    send_item(npcs_pkg::CmdLoad, 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    send_item(npcs_pkg::CmdMatch, 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = npcs_pkg::CmdLoad;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_palette();
    test_no_closer_entry();
    test_ties_and_black();
    test_component_extremes();
    test_random_palette();

    test_random_traffic(TrafficItems);
    test_output_backpressure();

    src_idle_pct = IdleHeavy;
    test_random_traffic(TrafficItems);
    test_drain_pause();

    src_idle_pct = 0;
    snk_idle_pct = IdleHeavy;
    test_random_traffic(TrafficItems);

    src_idle_pct = IdleLight;
    snk_idle_pct = IdleLight;
    test_random_traffic(TrafficItems);
    test_output_backpressure();

    wait_results_drained(SettleCycles);
    if (mismatches == 0 && nearest_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
